// ----- rtl/rma_pkg.sv -----
// Shared types, opcodes and controller commands for the ranged modular ALU.
`timescale 1ns / 1ps
package rma_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int OP_WIDTH   = 4;
	localparam int CMD_WIDTH  = 4;

	localparam logic [OP_WIDTH-1:0] OP_ASSIGN = 4'd0;
	localparam logic [OP_WIDTH-1:0] OP_ADD    = 4'd1;
	localparam logic [OP_WIDTH-1:0] OP_SUB    = 4'd2;
	localparam logic [OP_WIDTH-1:0] OP_RSUB   = 4'd3;
	localparam logic [OP_WIDTH-1:0] OP_NEG    = 4'd4;
	localparam logic [OP_WIDTH-1:0] OP_MUL    = 4'd5;
	localparam logic [OP_WIDTH-1:0] OP_DIV    = 4'd6;
	localparam logic [OP_WIDTH-1:0] OP_RDIV   = 4'd7;
	localparam logic [OP_WIDTH-1:0] OP_INC    = 4'd8;
	localparam logic [OP_WIDTH-1:0] OP_DEC    = 4'd9;
	localparam logic [OP_WIDTH-1:0] OP_SHR    = 4'd10;
	localparam logic [OP_WIDTH-1:0] OP_CMP    = 4'd11;

	localparam logic CFG_MIN = 1'b0;
	localparam logic CFG_MAX = 1'b1;

	localparam logic [CMD_WIDTH-1:0] CMD_NONE     = 4'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_LOAD     = 4'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_MUL_STEP = 4'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_MUL_END  = 4'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_DIV_STEP = 4'd4;
	localparam logic [CMD_WIDTH-1:0] CMD_DIV_END  = 4'd5;
	localparam logic [CMD_WIDTH-1:0] CMD_RED_INIT = 4'd6;
	localparam logic [CMD_WIDTH-1:0] CMD_RED_STEP = 4'd7;
	localparam logic [CMD_WIDTH-1:0] CMD_RED_END  = 4'd8;
	localparam logic [CMD_WIDTH-1:0] CMD_FINISH   = 4'd9;

	typedef struct packed {
		logic [OP_WIDTH-1:0]          op;
		logic signed [DATA_WIDTH-1:0] operand;
		logic                         keep;
	} rma_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] result_value;
		logic                         error;
		logic                         less;
		logic                         equal;
		logic                         greater;
	} rma_out_t;

	typedef struct packed {
		logic [CMD_WIDTH-1:0] code;
	} rma_cmd_t;

	typedef struct packed {
		logic err;
		logic cmp;
		logic mul;
		logic div;
		logic cnt_zero;
	} rma_status_t;

endpackage

// ----- rtl/rma_datapath.sv -----
// Datapath: stored value, range registers, shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
module rma_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [rma_pkg::DATA_WIDTH-1:0] cfg_wdata,
	input  rma_pkg::rma_in_t    req,
	input  rma_pkg::rma_cmd_t   cmd,
	output rma_pkg::rma_status_t status,
	output rma_pkg::rma_out_t   rsp
);

	localparam int W    = rma_pkg::DATA_WIDTH;
	localparam int XW   = 2 * W + 1;
	localparam int RW   = W + 1;
	localparam int REMW = W + 2;
	localparam int CW   = $clog2(XW + 1);
	localparam int SW   = $clog2(W);

	logic signed [W-1:0]        min_q;
	logic signed [W-1:0]        max_q;
	logic signed [W-1:0]        cur_q;
	logic [rma_pkg::OP_WIDTH-1:0] op_q;
	logic signed [W-1:0]        b_q;
	logic                       keep_q;
	logic                       err_q;
	logic signed [XW-1:0]       acc_q;
	logic [XW-1:0]              mcand_q;
	logic [W-1:0]               mplier_q;
	logic [XW-1:0]              dvd_q;
	logic [REMW-1:0]            rem_q;
	logic [RW-1:0]              dsr_q;
	logic                       neg_q;
	logic [CW-1:0]              cnt_q;
	logic signed [W-1:0]        res_q;
	rma_pkg::rma_out_t          rsp_q;

	logic signed [XW-1:0] a_x;
	logic signed [XW-1:0] b_x;
	logic signed [XW-1:0] simple;
	logic [W-1:0]         a_mag;
	logic [W-1:0]         b_mag;
	logic                 range_bad;
	logic                 shift_bad;
	logic                 pre_err;
	logic [REMW-1:0]      rem_sh;
	logic [REMW-1:0]      rem_diff;
	logic                 q_bit;
	logic signed [XW-1:0] d_red;
	logic [RW-1:0]        range_r;
	logic [RW-1:0]        m_raw;
	logic [RW-1:0]        m_fix;
	logic                 fail;

	always_comb begin
		a_x       = {{(XW-W){cur_q[W-1]}}, cur_q};
		b_x       = {{(XW-W){req.operand[W-1]}}, req.operand};
		a_mag     = cur_q[W-1] ? W'(-cur_q) : W'(cur_q);
		b_mag     = req.operand[W-1] ? W'(-req.operand) : W'(req.operand);
		range_bad = max_q < min_q;
		shift_bad = req.operand[W-1] || (req.operand > W'(W - 1));
		case (req.op)
			rma_pkg::OP_ASSIGN: simple = b_x;
			rma_pkg::OP_ADD:    simple = a_x + b_x;
			rma_pkg::OP_SUB:    simple = a_x - b_x;
			rma_pkg::OP_RSUB:   simple = b_x - a_x;
			rma_pkg::OP_NEG:    simple = -a_x;
			rma_pkg::OP_INC:    simple = a_x + XW'(1);
			rma_pkg::OP_DEC:    simple = a_x - XW'(1);
			rma_pkg::OP_SHR:    simple = a_x >>> req.operand[SW-1:0];
			default:            simple = '0;
		endcase
		if (req.op == rma_pkg::OP_CMP) begin
			pre_err = 1'b0;
		end else begin
			pre_err = (req.op > rma_pkg::OP_CMP) || range_bad
				|| ((req.op == rma_pkg::OP_SHR) && shift_bad)
				|| ((req.op == rma_pkg::OP_DIV) && (req.operand == '0))
				|| ((req.op == rma_pkg::OP_RDIV) && (cur_q == '0));
		end
	end

	always_comb begin
		rem_sh   = {rem_q[REMW-2:0], dvd_q[XW-1]};
		rem_diff = rem_sh - REMW'(dsr_q);
		q_bit    = rem_sh >= REMW'(dsr_q);
		d_red    = acc_q - {{(XW-W){min_q[W-1]}}, min_q};
		range_r  = {max_q[W-1], max_q} - {min_q[W-1], min_q} + RW'(1);
		m_raw    = rem_q[RW-1:0];
		m_fix    = (neg_q && (m_raw != '0)) ? dsr_q - m_raw : m_raw;
		fail     = err_q || (op_q == rma_pkg::OP_CMP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '0;
			cur_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == rma_pkg::CFG_MIN) begin
					min_q <= cfg_wdata;
				end else begin
					max_q <= cfg_wdata;
				end
			end
			if ((cmd.code == rma_pkg::CMD_FINISH) && !fail && !keep_q) begin
				cur_q <= res_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			rma_pkg::CMD_LOAD: begin
				op_q     <= req.op;
				b_q      <= req.operand;
				keep_q   <= req.keep;
				err_q    <= pre_err;
				acc_q    <= (req.op == rma_pkg::OP_MUL) ? '0 : simple;
				mcand_q  <= XW'(a_mag);
				mplier_q <= b_mag;
				neg_q    <= cur_q[W-1] ^ req.operand[W-1];
				dvd_q    <= XW'((req.op == rma_pkg::OP_RDIV) ? b_mag : a_mag);
				dsr_q    <= RW'((req.op == rma_pkg::OP_RDIV) ? a_mag : b_mag);
				rem_q    <= '0;
				cnt_q    <= (req.op == rma_pkg::OP_MUL) ? CW'(W) : CW'(XW);
			end
			rma_pkg::CMD_MUL_STEP: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + $signed(mcand_q);
				end
				mcand_q  <= {mcand_q[XW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[W-1:1]};
				cnt_q    <= cnt_q - CW'(1);
			end
			rma_pkg::CMD_MUL_END: begin
				acc_q <= neg_q ? -acc_q : acc_q;
			end
			rma_pkg::CMD_DIV_STEP, rma_pkg::CMD_RED_STEP: begin
				rem_q <= q_bit ? rem_diff : rem_sh;
				dvd_q <= {dvd_q[XW-2:0], q_bit};
				cnt_q <= cnt_q - CW'(1);
			end
			rma_pkg::CMD_DIV_END: begin
				if (rem_q != '0) begin
					err_q <= 1'b1;
				end
				acc_q <= neg_q ? -$signed(dvd_q) : $signed(dvd_q);
			end
			rma_pkg::CMD_RED_INIT: begin
				neg_q <= d_red[XW-1];
				dvd_q <= d_red[XW-1] ? XW'(-d_red) : XW'(d_red);
				dsr_q <= range_r;
				rem_q <= '0;
				cnt_q <= CW'(XW);
			end
			rma_pkg::CMD_RED_END: begin
				res_q <= min_q + $signed(m_fix[W-1:0]);
			end
			rma_pkg::CMD_FINISH: begin
				rsp_q.result_value <= fail ? cur_q : res_q;
				rsp_q.error        <= err_q;
				rsp_q.less    <= (op_q == rma_pkg::OP_CMP) && (cur_q < b_q);
				rsp_q.equal   <= (op_q == rma_pkg::OP_CMP) && (cur_q == b_q);
				rsp_q.greater <= (op_q == rma_pkg::OP_CMP) && (cur_q > b_q);
			end
			default: begin
			end
		endcase
	end

	assign status.err      = err_q;
	assign status.cmp      = op_q == rma_pkg::OP_CMP;
	assign status.mul      = op_q == rma_pkg::OP_MUL;
	assign status.div      = op_q inside {rma_pkg::OP_DIV, rma_pkg::OP_RDIV};
	assign status.cnt_zero = cnt_q == '0;
	assign rsp             = rsp_q;

endmodule

// ----- rtl/rma_ctrl.sv -----
// Controller state machine: sequences load, multiply, divide, reduce and result beat.
`timescale 1ns / 1ps
module rma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rma_pkg::rma_status_t status,
	output rma_pkg::rma_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_POST = 3'd4;
	localparam logic [2:0] S_RINI = 3'd5;
	localparam logic [2:0] S_RED  = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;
	logic       slot_free;

	assign slot_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d  = state_q;
		cmd.code = rma_pkg::CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = rma_pkg::CMD_LOAD;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				if (status.err || status.cmp) begin
					state_d = S_FIN;
				end else if (status.mul) begin
					state_d = S_MUL;
				end else if (status.div) begin
					state_d = S_DIV;
				end else begin
					state_d = S_RINI;
				end
			end
			S_MUL: begin
				if (status.cnt_zero) begin
					cmd.code = rma_pkg::CMD_MUL_END;
					state_d  = S_RINI;
				end else begin
					cmd.code = rma_pkg::CMD_MUL_STEP;
				end
			end
			S_DIV: begin
				if (status.cnt_zero) begin
					cmd.code = rma_pkg::CMD_DIV_END;
					state_d  = S_POST;
				end else begin
					cmd.code = rma_pkg::CMD_DIV_STEP;
				end
			end
			S_POST: begin
				state_d = status.err ? S_FIN : S_RINI;
			end
			S_RINI: begin
				cmd.code = rma_pkg::CMD_RED_INIT;
				state_d  = S_RED;
			end
			S_RED: begin
				if (status.cnt_zero) begin
					cmd.code = rma_pkg::CMD_RED_END;
					state_d  = S_FIN;
				end else begin
					cmd.code = rma_pkg::CMD_RED_STEP;
				end
			end
			S_FIN: begin
				if (slot_free) begin
					cmd.code = rma_pkg::CMD_FINISH;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.code == rma_pkg::CMD_FINISH) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/ranged_modular_alu.sv -----
// Top level of the ranged modular ALU: controller plus datapath.
// One item is taken at a time; the stored value is read by each item and updated
// before the next is taken, unless keep is set or the op is a compare or faults.
// Every op but compare and faulted ops reduces its exact result into [min_value,
// max_value] with a one-bit-per-cycle restoring divider running 2*DATA_WIDTH+1 steps;
// multiply first runs the shift-add multiplier, and divide/reverse divide first run a
// divider pass for the quotient. Compare and faulted ops skip the reduction and end in
// the result beat, which sits in an output register, so the next item is taken while
// it waits. The user must write range registers only while idle; it is not enforced.
`timescale 1ns / 1ps
module ranged_modular_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [rma_pkg::DATA_WIDTH-1:0] cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rma_pkg::rma_in_t     req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rma_pkg::rma_out_t    rsp
);

	rma_pkg::rma_cmd_t    cmd;
	rma_pkg::rma_status_t status;

	rma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rma_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp)
	);

endmodule
